### rtl/core/text_console_glyph_renderer_core_defines.svh
// Assertion macros shared by the glyph renderer RTL.
// Needs clk and rst_n in scope where a macro is used.
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define TCGR_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define TCGR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/tcgr_pkg.sv
// Package for the text console glyph renderer: constants, codes and the
// controller/datapath handshake structs. No dependencies.
package tcgr_pkg;

    // Screen and font geometry
    localparam int SCREEN_WIDTH  = 1024;
    localparam int SCREEN_HEIGHT = 768;
    localparam int GLYPH_SIZE    = 8;
    localparam int GLYPH_COUNT   = 256;

    // Field and storage widths
    localparam int COORD_W    = 10;
    localparam int CODE_W     = 8;
    localparam int GROW_W     = 3;
    localparam int VAL_W      = 8;
    localparam int WORD_W     = 32;
    localparam int GS_W       = $clog2(GLYPH_SIZE);
    localparam int GC_W       = $clog2(GLYPH_COUNT);
    localparam int ROW_AW     = $clog2(GLYPH_COUNT * GLYPH_SIZE);
    localparam int BIT_IDX_W  = $clog2(VAL_W);
    localparam int COL_SUM_W  = $clog2(SCREEN_WIDTH) + 2;
    localparam int ROW_SUM_W  = $clog2(SCREEN_HEIGHT) + 2;
    localparam int PADDR_W    = 3;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 104;

    localparam logic [CODE_W-1:0] NEWLINE_CODE     = 8'd10;
    localparam logic [WORD_W-1:0] FRAME_BASE_RESET = 32'h7f60_0000;
    localparam logic [WORD_W-1:0] TEXT_COLOR_RESET = 32'h00ff_ffff;

    // Register map indexes (byte address 4*index)
    localparam logic REG_FRAME_BASE = 1'b0;
    localparam logic REG_TEXT_COLOR = 1'b1;

    typedef enum logic [1:0] {
        CMD_PUT_CHAR   = 2'd0,
        CMD_LOAD_ROW   = 2'd1,
        CMD_LOAD_WIDTH = 2'd2,
        CMD_HOME       = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // take the input beat
        logic step;       // advance the glyph scan by one pixel
        logic capture;    // latch the current pixel as pending
        logic emit_pend;  // move the pending pixel to the output, not last
        logic finish;     // load the closing result of this item
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_draw;    // input beat is a put-char that scans a glyph
        logic pix_hit;    // current scan pixel is set and on screen
        logic scan_end;   // current scan pixel is the last of the glyph
        logic pend_valid; // a pixel waits in the pending slot
        logic out_free;   // output register can take a beat this cycle
    } dp_status_t;

endpackage

### rtl/core/tcgr_ctrl.sv
// Control state machine for the glyph renderer: sequences accept, scan and
// finish of each item. Depends on tcgr_pkg.
module tcgr_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  tcgr_pkg::dp_status_t  status,
    output tcgr_pkg::ctrl_cmd_t   cmd
);

    tcgr_pkg::state_t state_reg;
    tcgr_pkg::state_t state_next;
    logic             stall;

    // Hold the scan while a second hit finds the output still full
    assign stall = status.pix_hit && status.pend_valid && !status.out_free;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcgr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tcgr_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = status.is_draw ? tcgr_pkg::ST_SCAN : tcgr_pkg::ST_FINISH;
                end
            end
            tcgr_pkg::ST_SCAN:
            begin
                if (!stall && status.scan_end)
                begin
                    state_next = tcgr_pkg::ST_FINISH;
                end
            end
            tcgr_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = tcgr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcgr_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        s_tready      = 1'b0;
        cmd           = '0;
        case (state_reg)
            tcgr_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            tcgr_pkg::ST_SCAN:
            begin
                cmd.step      = !stall;
                cmd.capture   = status.pix_hit && !stall;
                cmd.emit_pend = status.pix_hit && status.pend_valid && status.out_free;
            end
            tcgr_pkg::ST_FINISH:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/core/tcgr_datapath.sv
// Datapath of the glyph renderer: glyph and width stores, cursor, scan
// counters, pending pixel and output register. Depends on tcgr_pkg.
module tcgr_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tcgr_pkg::ctrl_cmd_t                  cmd,
    output tcgr_pkg::dp_status_t                 status,
    input  logic [tcgr_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic [1:0]                           s_tuser,
    input  logic [tcgr_pkg::WORD_W-1:0]          frame_base,
    input  logic [tcgr_pkg::WORD_W-1:0]          text_color,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [tcgr_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                 m_tuser,
    output logic                                 m_tlast
);

    // Input field decode
    tcgr_pkg::cmd_t                    in_cmd;
    logic [tcgr_pkg::CODE_W-1:0]       in_code;
    logic [tcgr_pkg::GROW_W-1:0]       in_grow;
    logic [tcgr_pkg::VAL_W-1:0]        in_val;
    logic [tcgr_pkg::GC_W-1:0]         in_glyph;

    // Stores
    logic [tcgr_pkg::VAL_W-1:0]        glyph_mem [tcgr_pkg::GLYPH_COUNT*tcgr_pkg::GLYPH_SIZE];
    logic [tcgr_pkg::VAL_W-1:0]        width_mem [tcgr_pkg::GLYPH_COUNT];
    logic [tcgr_pkg::VAL_W-1:0]        glyph_rdata_reg;
    logic [tcgr_pkg::VAL_W-1:0]        width_rdata_reg;
    logic                              row_wr_en;
    logic [tcgr_pkg::ROW_AW-1:0]       row_wr_addr;
    logic                              row_rd_en;
    logic [tcgr_pkg::ROW_AW-1:0]       row_rd_addr;

    // Scan state
    logic [tcgr_pkg::GC_W-1:0]         glyph_sel_reg;
    logic [tcgr_pkg::COORD_W-1:0]      base_row_reg;
    logic [tcgr_pkg::COORD_W-1:0]      base_col_reg;
    logic [tcgr_pkg::GS_W-1:0]         row_cnt_reg;
    logic [tcgr_pkg::GS_W-1:0]         col_cnt_reg;
    logic                              row_end;
    logic                              col_end;
    logic                              scan_first;
    logic [tcgr_pkg::BIT_IDX_W-1:0]    bit_idx;
    logic                              pix_bit;
    logic [tcgr_pkg::COORD_W:0]        px_wide;
    logic [tcgr_pkg::COORD_W:0]        py_wide;
    logic                              visible;
    logic [tcgr_pkg::WORD_W-1:0]       pix_addr;

    // Cursor
    logic [tcgr_pkg::COORD_W-1:0]      cursor_row_reg;
    logic [tcgr_pkg::COORD_W-1:0]      cursor_col_reg;
    logic [tcgr_pkg::ROW_SUM_W-1:0]    row_sum;
    logic [tcgr_pkg::COORD_W-1:0]      nl_row;
    logic [tcgr_pkg::COL_SUM_W-1:0]    col_sum;
    logic                              col_wrap;

    // Pending pixel
    logic                              pend_valid_reg;
    logic [tcgr_pkg::COORD_W-1:0]      pend_x_reg;
    logic [tcgr_pkg::COORD_W-1:0]      pend_y_reg;
    logic [tcgr_pkg::WORD_W-1:0]       pend_addr_reg;

    // Output register
    logic                              m_tvalid_reg;
    logic [tcgr_pkg::COORD_W-1:0]      out_x_reg;
    logic [tcgr_pkg::COORD_W-1:0]      out_y_reg;
    logic [tcgr_pkg::WORD_W-1:0]       out_addr_reg;
    logic [tcgr_pkg::WORD_W-1:0]       out_color_reg;
    logic                              out_we_reg;
    logic                              out_last_reg;
    logic [tcgr_pkg::COORD_W-1:0]      out_row_reg;
    logic [tcgr_pkg::COORD_W-1:0]      out_col_reg;
    logic                              out_free;

    assign in_cmd   = tcgr_pkg::cmd_t'(s_tuser);
    assign in_code  = s_tdata[7:0];
    assign in_grow  = s_tdata[10:8];
    assign in_val   = s_tdata[18:11];
    assign in_glyph = in_code[tcgr_pkg::GC_W-1:0];

    // Store addressing: row loads at accept, row reads at accept and row turns
    assign row_end     = (row_cnt_reg == tcgr_pkg::GS_W'(tcgr_pkg::GLYPH_SIZE - 1));
    assign col_end     = (col_cnt_reg == tcgr_pkg::GS_W'(tcgr_pkg::GLYPH_SIZE - 1));
    assign scan_first  = (row_cnt_reg == '0) && (col_cnt_reg == '0);
    assign row_wr_en   = cmd.accept && (in_cmd == tcgr_pkg::CMD_LOAD_ROW)
                         && (32'(in_grow) < tcgr_pkg::GLYPH_SIZE);
    assign row_wr_addr = tcgr_pkg::ROW_AW'(32'(in_glyph) * tcgr_pkg::GLYPH_SIZE + 32'(in_grow));
    assign row_rd_en   = cmd.accept || (cmd.step && col_end && !row_end);
    assign row_rd_addr = cmd.accept
        ? tcgr_pkg::ROW_AW'(32'(in_glyph) * tcgr_pkg::GLYPH_SIZE)
        : tcgr_pkg::ROW_AW'(32'(glyph_sel_reg) * tcgr_pkg::GLYPH_SIZE
                            + 32'(row_cnt_reg) + 32'd1);

    // Glyph row store
    always_ff @(posedge clk)
    begin
        if (row_wr_en)
        begin
            glyph_mem[row_wr_addr] <= in_val;
        end
        if (row_rd_en)
        begin
            glyph_rdata_reg <= glyph_mem[row_rd_addr];
        end
    end

    // Advance width store
    always_ff @(posedge clk)
    begin
        if (cmd.accept && (in_cmd == tcgr_pkg::CMD_LOAD_WIDTH))
        begin
            width_mem[in_glyph] <= in_val;
        end
        if (cmd.accept)
        begin
            width_rdata_reg <= width_mem[in_glyph];
        end
    end

    // Current pixel: leftmost bit first, clipped to the screen
    assign bit_idx  = tcgr_pkg::BIT_IDX_W'(tcgr_pkg::GLYPH_SIZE - 1)
                      - tcgr_pkg::BIT_IDX_W'(col_cnt_reg);
    assign pix_bit  = glyph_rdata_reg[bit_idx];
    assign px_wide  = {1'b0, base_col_reg} + (tcgr_pkg::COORD_W+1)'(col_cnt_reg);
    assign py_wide  = {1'b0, base_row_reg} + (tcgr_pkg::COORD_W+1)'(row_cnt_reg);
    assign visible  = (32'(px_wide) < tcgr_pkg::SCREEN_WIDTH)
                      && (32'(py_wide) < tcgr_pkg::SCREEN_HEIGHT);
    assign pix_addr = frame_base
        + ((32'(py_wide) * tcgr_pkg::SCREEN_WIDTH + 32'(px_wide)) << 2);

    // Cursor arithmetic: next line with saturation, advance with wrap
    assign row_sum  = tcgr_pkg::ROW_SUM_W'(cursor_row_reg)
                      + tcgr_pkg::ROW_SUM_W'(tcgr_pkg::GLYPH_SIZE + 1);
    assign nl_row   = (32'(row_sum) > tcgr_pkg::SCREEN_HEIGHT)
                      ? tcgr_pkg::COORD_W'(tcgr_pkg::SCREEN_HEIGHT)
                      : row_sum[tcgr_pkg::COORD_W-1:0];
    assign col_sum  = tcgr_pkg::COL_SUM_W'(cursor_col_reg)
                      + tcgr_pkg::COL_SUM_W'(width_rdata_reg) + tcgr_pkg::COL_SUM_W'(1);
    assign col_wrap = (32'(col_sum) + tcgr_pkg::GLYPH_SIZE) > tcgr_pkg::SCREEN_WIDTH;

    // Cursor registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if (in_cmd == tcgr_pkg::CMD_HOME)
            begin
                cursor_row_reg <= '0;
                cursor_col_reg <= '0;
            end
            else if ((in_cmd == tcgr_pkg::CMD_PUT_CHAR) && (in_code == tcgr_pkg::NEWLINE_CODE))
            begin
                cursor_row_reg <= nl_row;
                cursor_col_reg <= '0;
            end
        end
        else if (cmd.step && scan_first)
        begin
            // Width read is back: move the cursor past this glyph
            if (col_wrap)
            begin
                cursor_row_reg <= nl_row;
                cursor_col_reg <= '0;
            end
            else
            begin
                cursor_col_reg <= col_sum[tcgr_pkg::COORD_W-1:0];
            end
        end
    end

    // Scan origin and glyph select
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            glyph_sel_reg <= in_glyph;
            base_row_reg  <= cursor_row_reg;
            base_col_reg  <= cursor_col_reg;
        end
    end

    // Scan counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end
        else if (cmd.accept)
        begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end
        else if (cmd.step)
        begin
            col_cnt_reg <= col_end ? '0 : col_cnt_reg + 1'b1;
            if (col_end)
            begin
                row_cnt_reg <= row_end ? '0 : row_cnt_reg + 1'b1;
            end
        end
    end

    // Pending pixel slot: one hit of lookahead decides the last flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (cmd.finish || cmd.accept)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pend_x_reg    <= px_wide[tcgr_pkg::COORD_W-1:0];
            pend_y_reg    <= py_wide[tcgr_pkg::COORD_W-1:0];
            pend_addr_reg <= pix_addr;
        end
    end

    // Output register
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.emit_pend || cmd.finish)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_pend || (cmd.finish && pend_valid_reg))
        begin
            out_x_reg     <= pend_x_reg;
            out_y_reg     <= pend_y_reg;
            out_addr_reg  <= pend_addr_reg;
            out_color_reg <= text_color;
            out_we_reg    <= 1'b1;
            out_last_reg  <= cmd.finish;
            out_row_reg   <= cursor_row_reg;
            out_col_reg   <= cursor_col_reg;
        end
        else if (cmd.finish)
        begin
            // Empty action: one non-writing closing beat
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_addr_reg  <= '0;
            out_color_reg <= '0;
            out_we_reg    <= 1'b0;
            out_last_reg  <= 1'b1;
            out_row_reg   <= cursor_row_reg;
            out_col_reg   <= cursor_col_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_col_reg, out_row_reg, out_color_reg, out_addr_reg,
                       out_y_reg, out_x_reg};
    assign m_tuser  = out_we_reg;
    assign m_tlast  = out_last_reg;

    // Status to the controller
    assign status.is_draw    = (in_cmd == tcgr_pkg::CMD_PUT_CHAR)
                               && (in_code != tcgr_pkg::NEWLINE_CODE);
    assign status.pix_hit    = pix_bit && visible;
    assign status.scan_end   = row_end && col_end;
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;

endmodule

### rtl/core/tcgr_apb_regs.sv
// Configuration registers of the glyph renderer behind an APB-style port.
// Depends on tcgr_pkg.
module tcgr_apb_regs
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tcgr_pkg::PADDR_W-1:0]      paddr,
    input  logic [tcgr_pkg::WORD_W-1:0]       pwdata,
    output logic [tcgr_pkg::WORD_W-1:0]       prdata,
    output logic                              pready,
    output logic [tcgr_pkg::WORD_W-1:0]       frame_base,
    output logic [tcgr_pkg::WORD_W-1:0]       text_color
);

    logic [tcgr_pkg::WORD_W-1:0] frame_base_reg;
    logic [tcgr_pkg::WORD_W-1:0] text_color_reg;
    logic                        reg_idx;
    logic                        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg <= tcgr_pkg::FRAME_BASE_RESET;
            text_color_reg <= tcgr_pkg::TEXT_COLOR_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                tcgr_pkg::REG_FRAME_BASE: frame_base_reg <= pwdata;
                tcgr_pkg::REG_TEXT_COLOR: text_color_reg <= pwdata;
                default:                  frame_base_reg <= frame_base_reg;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            tcgr_pkg::REG_FRAME_BASE: prdata = frame_base_reg;
            tcgr_pkg::REG_TEXT_COLOR: prdata = text_color_reg;
            default:                  prdata = '0;
        endcase
    end

    assign frame_base = frame_base_reg;
    assign text_color = text_color_reg;

endmodule

### rtl/core/text_console_glyph_renderer_core.sv
// Top level of the text console glyph renderer: controller, datapath and
// configuration registers. Depends on tcgr_pkg and the defines header.
//
//  Channel   Dir  Handshake          Payload
//  s_*       in   tvalid/tready      tdata: code, glyph row, load value; tuser: command
//  m_*       out  tvalid/tready      tdata: x, y, address, color, cursor; tuser: we; tlast
//  apb       in   psel/penable/pwrite frame_base at 0x0, text_color at 0x4
//
//  Put-char runs accept, a scan of the 64 glyph pixels (one pixel per scan step,
//  a glyph row read from the row store at each row turn), then a closing result.
//  Loads, home and newline run accept and one closing result.
//  A full output register stalls the scan only when a second set pixel is found.
//  Reset clears the cursor and loads the register defaults; the glyph and width
//  stores are not cleared and must be loaded before use.
`include "text_console_glyph_renderer_core_defines.svh"

module text_console_glyph_renderer_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] char_code, [10:8] glyph_row, [18:11] load_value, [23:19] zero
    input  logic [tcgr_pkg::IN_DATA_W-1:0]    s_tdata,
    // [1:0] cmd
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [9:0] pixel_x, [19:10] pixel_y, [51:20] pixel_address,
    // [83:52] pixel_color, [93:84] cursor_row_out, [103:94] cursor_col_out
    output logic [tcgr_pkg::OUT_DATA_W-1:0]   m_tdata,
    // [0] write_enable
    output logic                              m_tuser,
    output logic                              m_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tcgr_pkg::PADDR_W-1:0]      paddr,
    input  logic [tcgr_pkg::WORD_W-1:0]       pwdata,
    output logic [tcgr_pkg::WORD_W-1:0]       prdata,
    output logic                              pready
);

    tcgr_pkg::ctrl_cmd_t          cmd;
    tcgr_pkg::dp_status_t         status;
    logic [tcgr_pkg::WORD_W-1:0]  frame_base;
    logic [tcgr_pkg::WORD_W-1:0]  text_color;

    tcgr_apb_regs u_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .frame_base (frame_base),
        .text_color (text_color)
    );

    tcgr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tcgr_datapath u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .frame_base (frame_base),
        .text_color (text_color),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // Checks
    `TCGR_ASSERT_NOW(a_empty_is_last, m_tvalid && !m_tuser, m_tlast, "non-writing beat without last")
    `TCGR_ASSERT_NEXT(a_one_item_at_a_time, s_tvalid && s_tready, !s_tready, "input taken twice in a row")
    `TCGR_ASSERT_NOW(a_pixel_on_screen, m_tvalid && m_tuser, 32'(m_tdata[19:10]) < tcgr_pkg::SCREEN_HEIGHT, "pixel below screen written")
    `TCGR_ASSERT_NOW(a_emit_needs_pending, cmd.emit_pend, status.pend_valid && status.out_free, "pending pixel emitted while empty or blocked")

endmodule
